// ----- src/cta_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cta_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int CTA_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CTA_CW      = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 64;
    localparam int CNT_W       = 32;

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_VERIFY   = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] source_addr;
        logic [ADDR_W-1:0] target_addr;
    } t_cta_in;

    typedef struct packed {
        logic             status;
        logic             allowed;
        logic [CNT_W-1:0] checks_seen;
        logic [CNT_W-1:0] violations_seen;
    } t_cta_out;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ----- src/cta_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ----- src/control_transfer_allowlist.sv -----
// Control-transfer allowlist.
// Input channel (i_in_valid / o_in_stall, payload i_in_data) carries one
// transaction: register a source/target pair, verify a transfer, or clear.
// Output channel (o_out_valid / i_out_stall, payload o_out_data) returns one
// transaction per input with status, allowed and both saturating counters.
// Pairs live in one single-port RAM of TABLE_DEPTH entries with a registered
// read. Register, clear and verify with a zero address or an empty table pass
// through EXEC and DONE before the result is registered at the output; the
// next transaction is accepted once back in IDLE, never before the last one is
// through. Verify scans the filled entries one per cycle through the RAM port
// in SCAN, from entry 0 up to a hit or to the end of the filled table (up to
// TABLE_DEPTH entries; an empty table is not scanned).
// The block works on one transaction at a time; the next one is accepted as
// soon as the previous result sits in the output register, even if the
// receiver has not taken it yet. While i_out_stall is high the output holds;
// a finished result then waits internally and o_in_stall stays high.
// Reset empties the table and zeroes both counters; RAM contents are not
// cleared and no entry at or above the fill count is ever compared.
`timescale 1ns / 1ps
`default_nettype none

module control_transfer_allowlist (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire cta_pkg::t_cta_in  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output cta_pkg::t_cta_out      o_out_data
);
    import cta_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [CTA_CW-1:0]       r_count, n_count;
    logic [CNT_W-1:0]        r_checks, n_checks;
    logic [CNT_W-1:0]        r_viols, n_viols;
    logic                    r_out_valid, n_out_valid;
    t_cta_out                r_out, n_out;
    t_cta_in                 r_item, n_item;
    logic [CTA_AW-1:0]       r_idx, n_idx;
    logic                    r_status, n_status;
    logic                    r_allowed, n_allowed;

    logic                    ram_we;
    logic [CTA_AW-1:0]       ram_addr;
    logic [2*ADDR_W-1:0]     ram_rdata;
    logic                    zero_addr;
    logic                    full;
    logic                    hit;
    logic                    last;

    cta_ram #(
        .WIDTH (2 * ADDR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata ({r_item.source_addr, r_item.target_addr}),
        .o_rdata (ram_rdata)
    );

    assign zero_addr = (r_item.source_addr == '0) || (r_item.target_addr == '0);
    assign full      = (r_count >= CTA_CW'(TABLE_DEPTH));
    assign hit       = (ram_rdata == {r_item.source_addr, r_item.target_addr});
    assign last      = ((CTA_CW'(r_idx) + CTA_CW'(1)) == r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_checks    = r_checks;
        n_viols     = r_viols;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_item      = r_item;
        n_idx       = r_idx;
        n_status    = r_status;
        n_allowed   = r_allowed;
        ram_we      = 1'b0;
        ram_addr    = r_idx + CTA_AW'(1);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_status  = 1'b0;
                n_allowed = 1'b0;
                n_state   = ST_DONE;
                unique case (r_item.operation)
                    OP_REGISTER: begin
                        if (zero_addr || full) begin
                            n_status = 1'b1;
                        end else begin
                            ram_we   = 1'b1;
                            ram_addr = r_count[CTA_AW-1:0];
                            n_count  = r_count + CTA_CW'(1);
                        end
                    end
                    OP_VERIFY: begin
                        if (!zero_addr) begin
                            n_checks = sat_inc(r_checks);
                            if (r_count == '0) begin
                                n_viols = sat_inc(r_viols);
                            end else begin
                                ram_addr = '0;
                                n_idx    = '0;
                                n_state  = ST_SCAN;
                            end
                        end
                    end
                    OP_CLEAR: begin
                        n_count  = '0;
                        n_checks = '0;
                        n_viols  = '0;
                    end
                    default: begin
                        n_status = 1'b1;
                    end
                endcase
            end
            ST_SCAN: begin
                if (hit) begin
                    n_allowed = 1'b1;
                    n_state   = ST_DONE;
                end else if (last) begin
                    n_viols = sat_inc(r_viols);
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + CTA_AW'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid           = 1'b1;
                    n_out.status          = r_status;
                    n_out.allowed         = r_allowed;
                    n_out.checks_seen     = r_checks;
                    n_out.violations_seen = r_viols;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_checks    <= '0;
            r_viols     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_checks    <= n_checks;
            r_viols     <= n_viols;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_item    <= n_item;
        r_idx     <= n_idx;
        r_status  <= n_status;
        r_allowed <= n_allowed;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- src/cta_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cta_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire cta_pkg::t_cta_in  i_in_data,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire cta_pkg::t_cta_out o_out_data
);
    import cta_pkg::*;

    logic unused_in;
    assign unused_in = i_in_valid ^ o_in_stall ^ (^i_in_data);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    a_viol_le_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.violations_seen <= o_out_data.checks_seen))
        else $error("violations exceed checks");

    a_status_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.status && o_out_data.allowed))
        else $error("error status with allowed transfer");

endmodule

bind control_transfer_allowlist cta_checker u_cta_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
